[rtl/dtr_pkg.sv]
package dtr_pkg;

  // Sizes of the vertex store
  localparam int MAX_VERTICES = 64;
  localparam int ROW_W        = 64;
  localparam int IDX_W        = 6;
  localparam int CNT_W        = 7;

  typedef logic [ROW_W-1:0] row_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // Vertex count in use: zero reads as one, large values saturate
  function automatic cnt_t active_count(cnt_t vc);
    cnt_t n;
    n = vc;
    if (vc == '0) begin
      n = cnt_t'(1);
    end else if (vc > cnt_t'(MAX_VERTICES)) begin
      n = cnt_t'(MAX_VERTICES);
    end
    return n;
  endfunction

  // Columns below n set
  function automatic row_t col_mask(cnt_t n);
    row_t m;
    if (n >= cnt_t'(ROW_W)) begin
      m = '1;
    end else begin
      m = (row_t'(1) << n) - row_t'(1);
    end
    return m;
  endfunction

endpackage

[rtl/dtr_row_mem.sv]
module dtr_row_mem
  import dtr_pkg::*;
(
  input  logic clk,
  input  logic we,
  input  idx_t waddr,
  input  row_t wdata,
  input  logic re,
  input  idx_t raddr,
  output row_t rdata
);

  row_t mem [MAX_VERTICES];
  row_t rdata_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/dtr_row_unit.sv]
module dtr_row_unit
  import dtr_pkg::*;
(
  input  row_t a,
  input  row_t b,
  input  row_t bit_vec,
  input  idx_t pos,
  input  row_t mask,
  output row_t y,
  output logic hit
);

  // Conditional row merge: y = (a | (bit_vec[pos] ? b : 0)) & mask
  assign hit = bit_vec[pos];
  assign y   = (a | (hit ? b : '0)) & mask;

endmodule

[rtl/dag_transitive_reduction_core.sv]
// Channel | Direction | Handshake           | Payload
// in_     | input     | in_valid, in_stall  | in_row_index, in_row_bits, in_last_row
// out_    | output    | out_valid, out_stall| out_row_index, out_row_bits, out_status, out_last
// cfg_    | input     | cfg_we              | cfg_wdata (vertex count)
//
// Rows load at one item per cycle while in_stall is low; after the last row in_stall
// stays high until the last reduced row or the cycle status is issued, the closure
// being swept through the single read port of the reach RAM by one row merge unit.
// A cyclic graph ends after the self-reach check with a single error-status result.
// Output stalls hold the sequencer in its emit states.
// Reset (rst_n, synchronous) clears control and sets vertex count to 64; RAMs not cleared.
module dag_transitive_reduction_core
  import dtr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [6:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  idx_t       in_row_index,
  input  row_t       in_row_bits,
  input  logic       in_last_row,
  output logic       out_valid,
  input  logic       out_stall,
  output idx_t       out_row_index,
  output row_t       out_row_bits,
  output logic       out_status,
  output logic       out_last
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_INIT     = 4'd1;
  localparam logic [3:0] S_FETCH_K  = 4'd2;
  localparam logic [3:0] S_LOAD_K   = 4'd3;
  localparam logic [3:0] S_SWEEP    = 4'd4;
  localparam logic [3:0] S_CHECK    = 4'd5;
  localparam logic [3:0] S_RD_ADJ   = 4'd6;
  localparam logic [3:0] S_ADJ_WAIT = 4'd7;
  localparam logic [3:0] S_ACC      = 4'd8;
  localparam logic [3:0] S_EMIT     = 4'd9;
  localparam logic [3:0] S_ERR      = 4'd10;

  logic [3:0] state_r, state_nxt;
  cnt_t       vc_r, vc_nxt;
  cnt_t       c_r, c_nxt;
  cnt_t       k_r, k_nxt;
  cnt_t       u_r, u_nxt;
  idx_t       p_r, p_nxt;
  logic       pv_r, pv_nxt;
  logic       cyc_r, cyc_nxt;
  row_t       rk_r, rk_nxt;
  row_t       row_r, row_nxt;
  row_t       acc_r, acc_nxt;

  logic       ov_r, ov_nxt;
  idx_t       oidx_r, oidx_nxt;
  row_t       obits_r, obits_nxt;
  logic       ost_r, ost_nxt;
  logic       olast_r, olast_nxt;

  cnt_t       n;
  row_t       cols;
  logic       out_free;
  logic       issue;
  logic       drained;

  logic       adj_we, adj_re, rch_we, rch_re;
  idx_t       adj_waddr, adj_raddr, rch_waddr, rch_raddr;
  row_t       adj_wdata, adj_rdata, rch_wdata, rch_rdata;

  row_t       ru_a, ru_b, ru_vec, ru_y;
  idx_t       ru_pos;
  logic       ru_hit;

  assign n        = active_count(vc_r);
  assign cols     = col_mask(n);
  assign out_free = !ov_r || !out_stall;
  assign issue    = (c_r < n);
  assign drained  = !issue && !pv_r;

  dtr_row_mem u_adj_mem (
    .clk   (clk),
    .we    (adj_we),
    .waddr (adj_waddr),
    .wdata (adj_wdata),
    .re    (adj_re),
    .raddr (adj_raddr),
    .rdata (adj_rdata)
  );

  dtr_row_mem u_reach_mem (
    .clk   (clk),
    .we    (rch_we),
    .waddr (rch_waddr),
    .wdata (rch_wdata),
    .re    (rch_re),
    .raddr (rch_raddr),
    .rdata (rch_rdata)
  );

  dtr_row_unit u_row_unit (
    .a       (ru_a),
    .b       (ru_b),
    .bit_vec (ru_vec),
    .pos     (ru_pos),
    .mask    (cols),
    .y       (ru_y),
    .hit     (ru_hit)
  );

  // Row merge operand selection
  always_comb begin
    ru_a   = '0;
    ru_b   = adj_rdata;
    ru_vec = '1;
    ru_pos = '0;
    case (state_r)
      S_SWEEP: begin
        ru_a   = rch_rdata;
        ru_b   = rk_r;
        ru_vec = rch_rdata;
        ru_pos = k_r[IDX_W-1:0];
      end
      S_CHECK: begin
        ru_a   = '0;
        ru_b   = '0;
        ru_vec = rch_rdata;
        ru_pos = p_r;
      end
      S_ACC: begin
        ru_a   = acc_r;
        ru_b   = rch_rdata;
        ru_vec = row_r;
        ru_pos = p_r;
      end
      default: begin
        ru_a   = '0;
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    vc_nxt    = vc_r;
    c_nxt     = c_r;
    k_nxt     = k_r;
    u_nxt     = u_r;
    p_nxt     = c_r[IDX_W-1:0];
    pv_nxt    = 1'b0;
    cyc_nxt   = cyc_r;
    rk_nxt    = rk_r;
    row_nxt   = row_r;
    acc_nxt   = acc_r;

    ov_nxt    = ov_r && out_stall;
    oidx_nxt  = oidx_r;
    obits_nxt = obits_r;
    ost_nxt   = ost_r;
    olast_nxt = olast_r;

    adj_we    = 1'b0;
    adj_waddr = in_row_index;
    adj_wdata = in_row_bits & cols;
    adj_re    = 1'b0;
    adj_raddr = c_r[IDX_W-1:0];
    rch_we    = 1'b0;
    rch_waddr = p_r;
    rch_wdata = ru_y;
    rch_re    = 1'b0;
    rch_raddr = c_r[IDX_W-1:0];

    if (cfg_we) begin
      vc_nxt = cfg_wdata;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          adj_we = 1'b1;
          if (in_last_row) begin
            c_nxt     = '0;
            state_nxt = S_INIT;
          end
        end
      end

      // Copy adjacency rows into the reach store
      S_INIT: begin
        if (issue) begin
          adj_re = 1'b1;
          c_nxt  = c_r + cnt_t'(1);
          pv_nxt = 1'b1;
        end
        if (pv_r) begin
          rch_we = 1'b1;
        end
        if (drained) begin
          k_nxt     = '0;
          state_nxt = S_FETCH_K;
        end
      end

      // Pivot row k of the closure
      S_FETCH_K: begin
        rch_re    = 1'b1;
        rch_raddr = k_r[IDX_W-1:0];
        state_nxt = S_LOAD_K;
      end

      S_LOAD_K: begin
        rk_nxt    = rch_rdata;
        c_nxt     = '0;
        state_nxt = S_SWEEP;
      end

      // Merge pivot row into every row that reaches k
      S_SWEEP: begin
        if (issue) begin
          rch_re = 1'b1;
          c_nxt  = c_r + cnt_t'(1);
          pv_nxt = 1'b1;
        end
        if (pv_r && ru_hit) begin
          rch_we = 1'b1;
        end
        if (drained) begin
          k_nxt = k_r + cnt_t'(1);
          c_nxt = '0;
          if (k_r + cnt_t'(1) == n) begin
            cyc_nxt   = 1'b0;
            state_nxt = S_CHECK;
          end else begin
            state_nxt = S_FETCH_K;
          end
        end
      end

      // Any vertex that reaches itself
      S_CHECK: begin
        if (issue) begin
          rch_re = 1'b1;
          c_nxt  = c_r + cnt_t'(1);
          pv_nxt = 1'b1;
        end
        if (pv_r && ru_hit) begin
          cyc_nxt = 1'b1;
        end
        if (drained) begin
          u_nxt     = '0;
          state_nxt = cyc_r ? S_ERR : S_RD_ADJ;
        end
      end

      S_RD_ADJ: begin
        adj_re    = 1'b1;
        adj_raddr = u_r[IDX_W-1:0];
        state_nxt = S_ADJ_WAIT;
      end

      S_ADJ_WAIT: begin
        row_nxt   = adj_rdata & cols;
        acc_nxt   = '0;
        c_nxt     = '0;
        state_nxt = S_ACC;
      end

      // Union of reach rows over the successors of u
      S_ACC: begin
        if (issue) begin
          rch_re = 1'b1;
          c_nxt  = c_r + cnt_t'(1);
          pv_nxt = 1'b1;
        end
        if (pv_r) begin
          acc_nxt = ru_y;
        end
        if (drained) begin
          state_nxt = S_EMIT;
        end
      end

      S_EMIT: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          oidx_nxt  = u_r[IDX_W-1:0];
          obits_nxt = row_r & ~acc_r;
          ost_nxt   = 1'b0;
          olast_nxt = (u_r + cnt_t'(1) == n);
          u_nxt     = u_r + cnt_t'(1);
          state_nxt = (u_r + cnt_t'(1) == n) ? S_IDLE : S_RD_ADJ;
        end
      end

      S_ERR: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          oidx_nxt  = '0;
          obits_nxt = '0;
          ost_nxt   = 1'b1;
          olast_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      vc_r    <= cnt_t'(MAX_VERTICES);
      c_r     <= '0;
      k_r     <= '0;
      u_r     <= '0;
      pv_r    <= 1'b0;
      cyc_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      vc_r    <= vc_nxt;
      c_r     <= c_nxt;
      k_r     <= k_nxt;
      u_r     <= u_nxt;
      pv_r    <= pv_nxt;
      cyc_r   <= cyc_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    p_r     <= p_nxt;
    rk_r    <= rk_nxt;
    row_r   <= row_nxt;
    acc_r   <= acc_nxt;
    oidx_r  <= oidx_nxt;
    obits_r <= obits_nxt;
    ost_r   <= ost_nxt;
    olast_r <= olast_nxt;
  end

  assign in_stall      = (state_r != S_IDLE);
  assign out_valid     = ov_r;
  assign out_row_index = oidx_r;
  assign out_row_bits  = obits_r;
  assign out_status    = ost_r;
  assign out_last      = olast_r;

endmodule

[sim/tb_dag_transitive_reduction_core.sv]
`timescale 1ns / 1ps

module tb_dag_transitive_reduction_core;
  import dtr_pkg::*;

  localparam logic        STATUS_OK     = 1'b0;
  localparam logic        STATUS_CYCLE  = 1'b1;
  // well above the run of all items at n = 64 with every result stalled
  localparam int unsigned CYCLE_LIMIT   = 20_000_000;
  localparam int          RANDOM_ITEMS  = 480;
  localparam int          SETTLE_CYCLES = 24;

  typedef enum int {SHAPE_DAG, SHAPE_CYCLE, SHAPE_SELF_LOOP, SHAPE_RELAUNCH} shape_t;

  typedef struct {
    idx_t row_index;
    row_t row_bits;
    logic status;
    logic last;
  } reduced_row_t;

  // Mirrors the row store and vertex count, predicts reduced rows per last item
  class reduction_tracker;
    logic [6:0]   count_reg;
    row_t         adjacency [MAX_VERTICES];
    reduced_row_t pending_rows [$];
    int           mismatches;

    function new();
      count_reg  = 7'd64;
      mismatches = 0;
      foreach (adjacency[i]) begin
        adjacency[i] = '0;
      end
    endfunction

    function void write_count(logic [6:0] value);
      count_reg = value;
    endfunction

    // zero means one vertex, anything past the store saturates
    function int vertices_in_use();
      int n;
      n = int'(count_reg);
      if (n == 0) begin
        n = 1;
      end else if (n > MAX_VERTICES) begin
        n = MAX_VERTICES;
      end
      return n;
    endfunction

    function row_t columns_in_use();
      row_t cols;
      int   n;
      n    = vertices_in_use();
      cols = '1;
      if (n < ROW_W) begin
        cols = (row_t'(1) << n) - row_t'(1);
      end
      return cols;
    endfunction

    function void note_row(idx_t index, row_t bits, logic last_row);
      int           n;
      row_t         cols;
      row_t         reach [MAX_VERTICES];
      row_t         row;
      row_t         covered;
      logic         cyclic;
      reduced_row_t r;
      n    = vertices_in_use();
      cols = columns_in_use();
      adjacency[index] = bits & cols;
      if (!last_row) begin
        return;
      end
      // Warshall closure over the vertices in use
      for (int i = 0; i < n; i++) begin
        reach[i] = adjacency[i] & cols;
      end
      for (int k = 0; k < n; k++) begin
        for (int i = 0; i < n; i++) begin
          if (reach[i][k]) begin
            reach[i] |= reach[k];
          end
        end
      end
      cyclic = 1'b0;
      for (int i = 0; i < n; i++) begin
        if (reach[i][i]) begin
          cyclic = 1'b1;
        end
      end
      if (cyclic) begin
        r.row_index = '0;
        r.row_bits  = '0;
        r.status    = STATUS_CYCLE;
        r.last      = 1'b1;
        pending_rows.insert(pending_rows.size(), r);
        return;
      end
      // drop u->v when another successor of u already reaches v
      for (int u = 0; u < n; u++) begin
        row     = adjacency[u] & cols;
        covered = '0;
        for (int w = 0; w < n; w++) begin
          if (row[w]) begin
            covered |= reach[w];
          end
        end
        r.row_index = idx_t'(u);
        r.row_bits  = row & ~covered;
        r.status    = STATUS_OK;
        r.last      = (u == n - 1);
        pending_rows.insert(pending_rows.size(), r);
      end
    endfunction

    function void check_result(idx_t index, row_t bits, logic status, logic last);
      reduced_row_t want;
      if (pending_rows.size() == 0) begin
        if (mismatches < 10) begin
          $display("unexpected result: index %0d bits %h status %0b last %0b",
                   index, bits, status, last);
        end
        mismatches++;
        return;
      end
      want = pending_rows.pop_front();
      if (want.row_index !== index || want.row_bits !== bits ||
          want.status !== status || want.last !== last) begin
        if (mismatches < 10) begin
          $display("mismatch: expected index %0d bits %h status %0b last %0b",
                   want.row_index, want.row_bits, want.status, want.last);
          $display("          actual   index %0d bits %h status %0b last %0b",
                   index, bits, status, last);
        end
        mismatches++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [6:0] cfg_wdata;
  logic       in_valid;
  logic       in_stall;
  idx_t       in_row_index;
  row_t       in_row_bits;
  logic       in_last_row;
  logic       out_valid;
  logic       out_stall;
  idx_t       out_row_index;
  row_t       out_row_bits;
  logic       out_status;
  logic       out_last;

  reduction_tracker        tracker;
  logic [6:0]              count_written;
  logic [MAX_VERTICES-1:0] rows_loaded;
  int                      vertex_order [MAX_VERTICES];
  int                      items_accepted;
  int                      gap_odds;
  bit                      quiet_end;
  int unsigned             cycle_count = 0;

  dag_transitive_reduction_core dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_row_index (in_row_index),
    .in_row_bits  (in_row_bits),
    .in_last_row  (in_last_row),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_row_index(out_row_index),
    .out_row_bits (out_row_bits),
    .out_status   (out_status),
    .out_last     (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      tracker.check_result(out_row_index, out_row_bits, out_status, out_last);
    end
  end

  // Receiver stalls in bursts
  initial begin : out_stall_gen
    forever begin
      @(negedge clk);
      if (rst_n && !quiet_end && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic row_t random_row();
    return {$urandom, $urandom};
  endfunction

  task automatic shuffle_order(int n);
    int j;
    int t;
    for (int i = n - 1; i > 0; i--) begin
      j               = $urandom_range(0, i);
      t               = vertex_order[i];
      vertex_order[i] = vertex_order[j];
      vertex_order[j] = t;
    end
  endtask

  // Drive one row item; returns at the falling edge after acceptance, valid still high
  task automatic send_row(idx_t index, row_t bits, logic last_row);
    if (!quiet_end && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_row_index <= index;
    in_row_bits  <= bits;
    in_last_row  <= last_row;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    tracker.note_row(index, bits, last_row);
    rows_loaded[index] = 1'b1;
    items_accepted++;
    @(negedge clk);
  endtask

  // Let all predicted rows come out, then give the block time to go idle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (tracker.pending_rows.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_vertex_count(logic [6:0] value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    tracker.write_count(value);
    @(negedge clk);
    cfg_we <= 1'b0;
    count_written = value;
  endtask

  // One graph: build rows in topological order, load them shuffled
  task automatic run_graph(shape_t shape);
    int   n;
    int   dens;
    int   a;
    int   b;
    int   v;
    bit   oor_tail;
    bit   closing;
    row_t cols;
    row_t rows [MAX_VERTICES];
    n    = tracker.vertices_in_use();
    cols = tracker.columns_in_use();
    if (shape == SHAPE_RELAUNCH) begin
      if ((rows_loaded & cols) == cols) begin
        // rerun on stored rows, one row rewritten
        send_row(idx_t'($urandom_range(0, MAX_VERTICES - 1)),
                 $urandom_range(0, 1) ? random_row() : (random_row() & ~cols), 1'b1);
        return;
      end
      shape = SHAPE_DAG;
    end
    for (int i = 0; i < n; i++) begin
      vertex_order[i] = i;
    end
    shuffle_order(n);
    dens = $urandom_range(1, 7);
    for (int i = 0; i < n; i++) begin
      // junk above the columns in use
      rows[vertex_order[i]] = random_row() & ~cols;
      for (int j = i + 1; j < n; j++) begin
        if ($urandom_range(0, 7) < dens) begin
          rows[vertex_order[i]][vertex_order[j]] = 1'b1;
        end
      end
    end
    if (shape == SHAPE_CYCLE && n >= 2) begin
      // path along the order, closed by a back edge
      a = $urandom_range(0, n - 2);
      b = $urandom_range(a + 1, n - 1);
      for (int i = a; i < b; i++) begin
        rows[vertex_order[i]][vertex_order[i + 1]] = 1'b1;
      end
      rows[vertex_order[b]][vertex_order[a]] = 1'b1;
    end else if (shape != SHAPE_DAG) begin
      v          = $urandom_range(0, n - 1);
      rows[v][v] = 1'b1;
    end
    shuffle_order(n);
    oor_tail = (n < MAX_VERTICES) && ($urandom_range(0, 5) == 0);
    for (int i = 0; i < n; i++) begin
      v       = vertex_order[i];
      closing = (i == n - 1) && !oor_tail;
      if (n < MAX_VERTICES && $urandom_range(0, 7) == 0) begin
        send_row(idx_t'($urandom_range(n, MAX_VERTICES - 1)), random_row(), 1'b0);
      end
      // a row stored earlier may be left as it is
      if (!closing && rows_loaded[v] && $urandom_range(0, 9) == 0) begin
        continue;
      end
      send_row(idx_t'(v), rows[v], closing);
    end
    if (oor_tail) begin
      send_row(idx_t'($urandom_range(n, MAX_VERTICES - 1)), random_row(), 1'b1);
    end
  endtask

  initial begin : stimulus
    int         first_random;
    int         graphs;
    int         n_pick;
    bit         big_done;
    logic [6:0] cfg_val;
    shape_t     shape;
    tracker        = new();
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    in_row_index   = '0;
    in_row_bits    = '0;
    in_last_row    = 1'b0;
    out_stall      = 1'b0;
    rows_loaded    = '0;
    items_accepted = 0;
    gap_odds       = 3;
    quiet_end      = 1'b0;
    count_written  = 7'd64;
    big_done       = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Single vertex: all-ones row is a self-loop, then an empty row
    write_vertex_count(7'd1);
    send_row(idx_t'(0), '1, 1'b1);
    send_row(idx_t'(0), '0, 1'b1);
    // Count zero acts as one vertex; higher bits are dropped
    write_vertex_count(7'd0);
    send_row(idx_t'(0), ~row_t'(1), 1'b1);
    // Four vertices with shortcut edges, plus an out-of-range row
    write_vertex_count(7'd4);
    send_row(idx_t'(63), '1, 1'b0);
    send_row(idx_t'(2), row_t'(4'b1000), 1'b0);
    send_row(idx_t'(0), row_t'(4'b1110), 1'b0);
    send_row(idx_t'(1), row_t'(4'b0100), 1'b0);
    send_row(idx_t'(3), row_t'(0), 1'b1);
    // Reload row 3 to close the loop 0->1->2->3->0
    send_row(idx_t'(3), row_t'(4'b0001), 1'b1);
    // Two-vertex cycle with junk above the columns in use
    write_vertex_count(7'd2);
    send_row(idx_t'(1), 64'hFFFF_0000_A5A5_5A59, 1'b0);
    send_row(idx_t'(0), row_t'(2'b10), 1'b1);
    // Three vertices with a shortcut, last row in the middle
    write_vertex_count(7'd3);
    send_row(idx_t'(0), row_t'(3'b110), 1'b0);
    send_row(idx_t'(2), row_t'(0), 1'b0);
    send_row(idx_t'(1), row_t'(3'b100), 1'b1);

    // Random graphs, mostly small, now and then the full store
    first_random = items_accepted;
    graphs       = 0;
    while (items_accepted - first_random < RANDOM_ITEMS) begin
      graphs++;
      if (graphs % 25 == 8) begin
        n_pick = MAX_VERTICES;
      end else begin
        case ($urandom_range(0, 19))
          0:       n_pick = 1;
          1:       n_pick = $urandom_range(13, 40);
          2, 3, 4: n_pick = $urandom_range(9, 12);
          default: n_pick = $urandom_range(2, 8);
        endcase
      end
      if (n_pick == 1) begin
        cfg_val = 7'($urandom_range(0, 1));
      end else if (n_pick == MAX_VERTICES) begin
        cfg_val  = big_done ? 7'($urandom_range(64, 127)) : 7'd127;
        big_done = 1'b1;
      end else begin
        cfg_val = 7'(n_pick);
      end
      if (items_accepted - first_random > RANDOM_ITEMS - 60) begin
        quiet_end = 1'b1;
      end
      if (cfg_val != count_written) begin
        write_vertex_count(cfg_val);
      end
      gap_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 5);
      case ($urandom_range(0, 9))
        0:       shape = SHAPE_CYCLE;
        1:       shape = SHAPE_SELF_LOOP;
        2:       shape = SHAPE_RELAUNCH;
        default: shape = SHAPE_DAG;
      endcase
      run_graph(shape);
    end

    wait_idle();
    if (tracker.mismatches == 0 && tracker.pending_rows.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
